/* sv/bqe_pkg.sv */
// Shared types, constants and helper functions for the billboard quad expander.
package bqe_pkg;

    localparam int CFG_AW     = 5;
    localparam int HALF_SHIFT = 15;
    localparam int POS_W      = 32 + HALF_SHIFT;
    localparam int OFF_W      = 16 + 33;
    localparam int SUM_W      = OFF_W + 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [2:0] CFG_RIGHT_X = 3'd0;
    localparam logic [2:0] CFG_RIGHT_Y = 3'd1;
    localparam logic [2:0] CFG_RIGHT_Z = 3'd2;
    localparam logic [2:0] CFG_UP_X    = 3'd3;
    localparam logic [2:0] CFG_UP_Y    = 3'd4;
    localparam logic [2:0] CFG_UP_Z    = 3'd5;

    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TR = 2'd2;
    localparam logic [1:0] CORNER_TL = 2'd3;

    localparam logic [16:0] CHAN_ONE = 17'd65536;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_cam;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [OFF_W-1:0] roff_x;
        logic signed [OFF_W-1:0] roff_y;
        logic signed [OFF_W-1:0] roff_z;
        logic signed [OFF_W-1:0] uoff_x;
        logic signed [OFF_W-1:0] uoff_y;
        logic signed [OFF_W-1:0] uoff_z;
        logic [31:0]             argb;
    } t_rec;

    // Clamp to 1.0, scale by 255, truncate to a byte.
    function automatic logic [7:0] chan_byte(input logic [16:0] c);
        logic [16:0] v;
        logic [24:0] p;
        v = (c > CHAN_ONE) ? CHAN_ONE : c;
        p = {8'd0, v} * 25'd255;
        return p[23:16];
    endfunction

    // Floor shift by HALF_SHIFT, then saturate to 32 bits signed.
    function automatic logic [31:0] corner_sat(input logic signed [SUM_W-1:0] n);
        logic signed [SUM_W-1:0]            s;
        logic signed [SUM_W-HALF_SHIFT-1:0] q;
        logic [31:0]                        res;
        s = n >>> HALF_SHIFT;
        q = s[SUM_W-HALF_SHIFT-1:0];
        if (q[SUM_W-HALF_SHIFT-1:31] == '0 || q[SUM_W-HALF_SHIFT-1:31] == '1) begin
            res = q[31:0];
        end else if (q[SUM_W-HALF_SHIFT-1]) begin
            res = 32'h8000_0000;
        end else begin
            res = 32'h7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

/* sv/billboard_quad_expander.sv */
// Billboard quad expander top level: configuration registers, front, queue and back.
// Path: an accepted request passes the front register and the queue into the back output
//   register; the other three corners follow one per cycle while pop is high.
// Throughput: one corner per cycle while pop is high, set by the back stage that emits
//   the corners one at a time from a single output register.
// Reset (synchronous, i_rst_n low): camera right = (1,0,0), up = (0,1,0) in Q1.14,
//   all queues and stages empty; payload registers keep their contents.
module billboard_quad_expander
    import bqe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // particle requests
    input  logic              push,
    output logic              full,
    input  logic [31:0]       i_pos_x,
    input  logic [31:0]       i_pos_y,
    input  logic [31:0]       i_pos_z,
    input  logic [31:0]       i_size,
    input  logic [16:0]       i_color_a,
    input  logic [16:0]       i_color_r,
    input  logic [16:0]       i_color_g,
    input  logic [16:0]       i_color_b,
    // corner requests
    output logic              empty,
    input  logic              pop,
    output logic [31:0]       o_vert_x,
    output logic [31:0]       o_vert_y,
    output logic [31:0]       o_vert_z,
    output logic [31:0]       o_packed_argb,
    output logic              o_tex_u,
    output logic              o_tex_v,
    output logic [1:0]        o_corner,
    output logic              o_last
);

    t_cam       r_cam;
    logic [2:0] cfg_idx;
    logic       cfg_wr;
    logic       q_push;
    logic       q_full;
    t_rec       q_in;
    t_rec       q_out;
    logic       q_empty;
    logic       q_pop;
    logic       out_valid;

    // Register index comes from the word address; indexes past the last register drop.
    assign cfg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam.right_x <= 16'sd16384;
            r_cam.right_y <= 16'sd0;
            r_cam.right_z <= 16'sd0;
            r_cam.up_x    <= 16'sd0;
            r_cam.up_y    <= 16'sd16384;
            r_cam.up_z    <= 16'sd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_RIGHT_X: r_cam.right_x <= pwdata[15:0];
                CFG_RIGHT_Y: r_cam.right_y <= pwdata[15:0];
                CFG_RIGHT_Z: r_cam.right_z <= pwdata[15:0];
                CFG_UP_X:    r_cam.up_x    <= pwdata[15:0];
                CFG_UP_Y:    r_cam.up_y    <= pwdata[15:0];
                CFG_UP_Z:    r_cam.up_z    <= pwdata[15:0];
                default:     r_cam         <= r_cam;
            endcase
        end
    end

    // Readback: zero-extend the 16-bit register, zero for unmapped addresses.
    always_comb begin
        unique case (cfg_idx)
            CFG_RIGHT_X: prdata = {16'd0, r_cam.right_x};
            CFG_RIGHT_Y: prdata = {16'd0, r_cam.right_y};
            CFG_RIGHT_Z: prdata = {16'd0, r_cam.right_z};
            CFG_UP_X:    prdata = {16'd0, r_cam.up_x};
            CFG_UP_Y:    prdata = {16'd0, r_cam.up_y};
            CFG_UP_Z:    prdata = {16'd0, r_cam.up_z};
            default:     prdata = 32'd0;
        endcase
    end

    // Front: take the particle, form pos*2^15, r*size, u*size and the ARGB word.
    bqe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cam     (r_cam),
        .i_push    (push),
        .o_full    (full),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_size    (i_size),
        .i_color_a (i_color_a),
        .i_color_r (i_color_r),
        .i_color_g (i_color_g),
        .i_color_b (i_color_b),
        .o_q_push  (q_push),
        .o_q_data  (q_in),
        .i_q_full  (q_full)
    );

    // Hold prepared particles so the front keeps accepting while the back emits corners.
    bqe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back: one corner per cycle while pop is high; drop the record after the top-left corner.
    bqe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (q_out),
        .i_rec_valid   (!q_empty),
        .o_rec_pop     (q_pop),
        .i_pop         (pop),
        .o_valid       (out_valid),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_vert_z      (o_vert_z),
        .o_packed_argb (o_packed_argb),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_corner      (o_corner),
        .o_last        (o_last)
    );

    assign empty = !out_valid;

endmodule

/* sv/bqe_front.sv */
// Front stage: accepts particles, forms the scaled offsets and the packed color.
module bqe_front
    import bqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cam        i_cam,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_size,
    input  logic [16:0] i_color_a,
    input  logic [16:0] i_color_r,
    input  logic [16:0] i_color_g,
    input  logic [16:0] i_color_b,
    output logic        o_q_push,
    output t_rec        o_q_data,
    input  logic        i_q_full
);

    logic                    r_valid;
    t_rec                    r_rec;
    t_rec                    n_rec;
    logic                    adv;
    logic signed [32:0]      size_s;

    assign size_s = $signed({1'b0, i_size});
    assign adv    = !r_valid || !i_q_full;

    always_comb begin
        n_rec.pos_x  = $signed({i_pos_x, HALF_SHIFT'(0)});
        n_rec.pos_y  = $signed({i_pos_y, HALF_SHIFT'(0)});
        n_rec.pos_z  = $signed({i_pos_z, HALF_SHIFT'(0)});
        n_rec.roff_x = i_cam.right_x * size_s;
        n_rec.roff_y = i_cam.right_y * size_s;
        n_rec.roff_z = i_cam.right_z * size_s;
        n_rec.uoff_x = i_cam.up_x * size_s;
        n_rec.uoff_y = i_cam.up_y * size_s;
        n_rec.uoff_z = i_cam.up_z * size_s;
        n_rec.argb   = {chan_byte(i_color_a), chan_byte(i_color_r),
                        chan_byte(i_color_g), chan_byte(i_color_b)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_push;
        end
        if (adv && i_push) begin
            r_rec <= n_rec;
        end
    end

    assign o_full   = !adv;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_rec;

endmodule

/* sv/bqe_queue.sv */
// Short queue of prepared particle records between front and back.
module bqe_queue
    import bqe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_data,
    output logic o_full,
    input  logic i_pop,
    output t_rec o_data,
    output logic o_empty
);

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* sv/bqe_back.sv */
// Back stage: steps through the four corners of each record into the output register.
module bqe_back
    import bqe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rec        i_rec,
    input  logic        i_rec_valid,
    output logic        o_rec_pop,
    input  logic        i_pop,
    output logic        o_valid,
    output logic [31:0] o_vert_x,
    output logic [31:0] o_vert_y,
    output logic [31:0] o_vert_z,
    output logic [31:0] o_packed_argb,
    output logic        o_tex_u,
    output logic        o_tex_v,
    output logic [1:0]  o_corner,
    output logic        o_last
);

    logic              r_out_valid;
    logic [1:0]        r_corner;
    logic [31:0]       r_vert_x;
    logic [31:0]       r_vert_y;
    logic [31:0]       r_vert_z;
    logic [31:0]       r_argb;
    logic [1:0]        r_out_corner;
    logic              adv;
    logic              rs;
    logic              us;
    logic [31:0]       n_vert_x;
    logic [31:0]       n_vert_y;
    logic [31:0]       n_vert_z;

    assign adv = i_rec_valid && (!r_out_valid || i_pop);

    // Right sign is positive on the right corners, up sign on the top corners.
    assign rs = (r_corner == CORNER_BR) || (r_corner == CORNER_TR);
    assign us = (r_corner == CORNER_TR) || (r_corner == CORNER_TL);

    function automatic logic signed [SUM_W-1:0] corner_sum(
        input logic signed [POS_W-1:0] p,
        input logic signed [OFF_W-1:0] ro,
        input logic signed [OFF_W-1:0] uo,
        input logic                    rp,
        input logic                    up
    );
        logic signed [SUM_W-1:0] pe;
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] ue;
        pe = SUM_W'(p);
        re = SUM_W'(ro);
        ue = SUM_W'(uo);
        return pe + (rp ? re : -re) + (up ? ue : -ue);
    endfunction

    assign n_vert_x = corner_sat(corner_sum(i_rec.pos_x, i_rec.roff_x, i_rec.uoff_x, rs, us));
    assign n_vert_y = corner_sat(corner_sum(i_rec.pos_y, i_rec.roff_y, i_rec.uoff_y, rs, us));
    assign n_vert_z = corner_sat(corner_sum(i_rec.pos_z, i_rec.roff_z, i_rec.uoff_z, rs, us));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_corner    <= CORNER_BL;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
                r_corner    <= r_corner + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (adv) begin
            r_vert_x     <= n_vert_x;
            r_vert_y     <= n_vert_y;
            r_vert_z     <= n_vert_z;
            r_argb       <= i_rec.argb;
            r_out_corner <= r_corner;
        end
    end

    assign o_rec_pop     = adv && (r_corner == CORNER_TL);
    assign o_valid       = r_out_valid;
    assign o_vert_x      = r_vert_x;
    assign o_vert_y      = r_vert_y;
    assign o_vert_z      = r_vert_z;
    assign o_packed_argb = r_argb;
    assign o_corner      = r_out_corner;
    assign o_tex_u       = (r_out_corner == CORNER_BR) || (r_out_corner == CORNER_TR);
    assign o_tex_v       = (r_out_corner == CORNER_BL) || (r_out_corner == CORNER_BR);
    assign o_last        = (r_out_corner == CORNER_TL);

    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_corner != CORNER_TL |=> r_corner == $past(r_corner) + 2'd1)
        else $error("corner counter skipped a corner");

    a_rec_pop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_pop |=> r_corner == CORNER_BL && r_out_valid && r_out_corner == CORNER_TL)
        else $error("record released before its last corner was emitted");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out_corner))
        else $error("waiting corner lost while stalled");

endmodule
